// ===== sv/esp3fr_pkg.sv =====
// ----------------------------------------------------------------------------
// esp3fr_pkg
// Types and constants shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
package esp3fr_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 16;
   localparam int CNT_W   = 17;
   localparam int STAT_W  = 2;
   localparam int KIND_W  = 2;

   localparam logic [BYTE_W-1:0] SYNC_CODE = 8'h55;
   localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h07;
   localparam logic [CNT_W-1:0]  HDR_BYTES = 17'd4;
   localparam logic [CNT_W-1:0]  PAYLOAD_LIMIT_RESET = 17'd65790;

   // status codes
   localparam logic [STAT_W-1:0] ST_BUSY  = 2'd0;
   localparam logic [STAT_W-1:0] ST_ERROR = 2'd1;
   localparam logic [STAT_W-1:0] ST_GOOD  = 2'd2;

   // error codes
   localparam logic [KIND_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [KIND_W-1:0] ERR_HDR_CRC  = 2'd1;
   localparam logic [KIND_W-1:0] ERR_DATA_CRC = 2'd2;
   localparam logic [KIND_W-1:0] ERR_TOO_LONG = 2'd3;

   typedef enum logic [2:0] {
      PH_SYNC   = 3'd0,
      PH_HEADER = 3'd1,
      PH_HCRC   = 3'd2,
      PH_DATA   = 3'd3,
      PH_OPT    = 3'd4,
      PH_DCRC   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [KIND_W-1:0] error_kind;
      logic              payload_valid;
      logic              payload_is_optional;
      logic [BYTE_W-1:0] payload_byte;
      logic [CNT_W-1:0]  payload_index;
      logic [LEN_W-1:0]  data_length;
      logic [BYTE_W-1:0] optional_length;
      logic [BYTE_W-1:0] pkt_type;
   } result_type;

   // crc-8, msb first, no reflection
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/esp3fr_parser.sv =====
// ----------------------------------------------------------------------------
// esp3fr_parser
// Frame state, header capture and crc tracking; forms one result per byte.
// ----------------------------------------------------------------------------
module esp3fr_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [esp3fr_pkg::BYTE_W-1:0]      rx_byte,
   input  logic [esp3fr_pkg::CNT_W-1:0]       payload_limit,
   output esp3fr_pkg::result_type             result
);

   esp3fr_pkg::phase_type              phase_ff, phase_in;
   logic [esp3fr_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [esp3fr_pkg::LEN_W-1:0]       dlen_ff, dlen_in;
   logic [esp3fr_pkg::BYTE_W-1:0]      olen_ff, olen_in;
   logic [esp3fr_pkg::BYTE_W-1:0]      crc_ff, crc_in;
   logic [esp3fr_pkg::BYTE_W-1:0]      hdr_ff [4];
   logic                               hdr_we;
   logic [esp3fr_pkg::CNT_W-1:0]       count_inc;
   logic [esp3fr_pkg::CNT_W-1:0]       hdr_total;
   logic [esp3fr_pkg::CNT_W-1:0]       reg_total;
   logic [esp3fr_pkg::LEN_W-1:0]       hdr_dlen;
   logic [esp3fr_pkg::BYTE_W-1:0]      crc_next;

   assign count_inc = count_ff + 17'd1;
   assign hdr_dlen  = {hdr_ff[0], hdr_ff[1]};
   assign hdr_total = {1'b0, hdr_dlen} + {9'd0, hdr_ff[2]};
   assign reg_total = {1'b0, dlen_ff} + {9'd0, olen_ff};
   assign crc_next  = esp3fr_pkg::crc8_update(crc_ff, rx_byte);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      dlen_in  = dlen_ff;
      olen_in  = olen_ff;
      crc_in   = crc_ff;
      hdr_we   = 1'b0;
      result   = '0;
      case (phase_ff)
         esp3fr_pkg::PH_HEADER: begin
            hdr_we   = 1'b1;
            crc_in   = crc_next;
            count_in = count_inc;
            if (count_inc >= esp3fr_pkg::HDR_BYTES) begin
               count_in = '0;
               phase_in = esp3fr_pkg::PH_HCRC;
            end
         end
         esp3fr_pkg::PH_HCRC: begin
            if (crc_ff != rx_byte) begin
               result.status     = esp3fr_pkg::ST_ERROR;
               result.error_kind = esp3fr_pkg::ERR_HDR_CRC;
               phase_in          = esp3fr_pkg::PH_SYNC;
            end else begin
               dlen_in  = hdr_dlen;
               olen_in  = hdr_ff[2];
               crc_in   = '0;
               count_in = '0;
               if (hdr_total > payload_limit) begin
                  result.status     = esp3fr_pkg::ST_ERROR;
                  result.error_kind = esp3fr_pkg::ERR_TOO_LONG;
                  phase_in          = esp3fr_pkg::PH_SYNC;
               end else if (hdr_dlen != '0) begin
                  phase_in = esp3fr_pkg::PH_DATA;
               end else if (hdr_ff[2] != '0) begin
                  phase_in = esp3fr_pkg::PH_OPT;
               end else begin
                  phase_in = esp3fr_pkg::PH_DCRC;
               end
            end
         end
         esp3fr_pkg::PH_DATA, esp3fr_pkg::PH_OPT: begin
            result.payload_valid       = 1'b1;
            result.payload_is_optional = (phase_ff == esp3fr_pkg::PH_OPT);
            result.payload_byte        = rx_byte;
            result.payload_index       = count_ff;
            crc_in                     = crc_next;
            count_in                   = count_inc;
            if (phase_ff == esp3fr_pkg::PH_DATA && count_inc >= {1'b0, dlen_ff}) begin
               phase_in = (olen_ff != '0) ? esp3fr_pkg::PH_OPT : esp3fr_pkg::PH_DCRC;
            end else if (phase_ff == esp3fr_pkg::PH_OPT && count_inc >= reg_total) begin
               phase_in = esp3fr_pkg::PH_DCRC;
            end
         end
         esp3fr_pkg::PH_DCRC: begin
            if (crc_ff != rx_byte) begin
               result.status     = esp3fr_pkg::ST_ERROR;
               result.error_kind = esp3fr_pkg::ERR_DATA_CRC;
            end else begin
               result.status          = esp3fr_pkg::ST_GOOD;
               result.data_length     = dlen_ff;
               result.optional_length = olen_ff;
               result.pkt_type        = hdr_ff[3];
            end
            phase_in = esp3fr_pkg::PH_SYNC;
         end
         default: begin
            // hunting: anything but the sync code is dropped
            phase_in = esp3fr_pkg::PH_SYNC;
            if (rx_byte == esp3fr_pkg::SYNC_CODE) begin
               phase_in = esp3fr_pkg::PH_HEADER;
               count_in = '0;
               crc_in   = '0;
               dlen_in  = '0;
               olen_in  = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= esp3fr_pkg::PH_SYNC;
         count_ff <= '0;
         dlen_ff  <= '0;
         olen_ff  <= '0;
         crc_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         dlen_ff  <= dlen_in;
         olen_ff  <= olen_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && hdr_we) begin
         hdr_ff[count_ff[1:0]] <= rx_byte;
      end
   end

`ifndef SYNTHESIS
   a_header_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == esp3fr_pkg::PH_HEADER |-> count_ff < esp3fr_pkg::HDR_BYTES)
      else $error("header byte count out of range");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == esp3fr_pkg::PH_DATA |-> count_ff < {1'b0, dlen_ff})
      else $error("data byte count passed data length");

   a_opt_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == esp3fr_pkg::PH_OPT |-> count_ff < reg_total && count_ff >= {1'b0, dlen_ff})
      else $error("optional byte count out of range");

   a_good_only_after_crc: assert property (@(posedge clock) disable iff (reset)
      step && result.status == esp3fr_pkg::ST_GOOD |=> phase_ff == esp3fr_pkg::PH_SYNC)
      else $error("good frame did not return to hunting");
`endif

endmodule

// ===== sv/esp3_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// esp3_frame_receiver
// Serial frame receiver: sync hunt, header with crc-8, streamed payload with
// running crc-8 and final check.
// ----------------------------------------------------------------------------
// path: an accepted byte waits in the input register until the result register
//   is free, then the parser result lands in the result register
// throughput: one request per cycle while the response side does not stall
//   (rsp_ready), set by the crc and count update in the parser
// reset: synchronous; returns to sync hunting, empties both registers and
//   restores the payload limit to 65790
module esp3_frame_receiver (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [esp3fr_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [esp3fr_pkg::STAT_W-1:0]      rsp_status,
   output logic [esp3fr_pkg::KIND_W-1:0]      rsp_error_kind,
   output logic                               rsp_payload_valid,
   output logic                               rsp_payload_is_optional,
   output logic [esp3fr_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic [esp3fr_pkg::CNT_W-1:0]       rsp_payload_index,
   output logic [esp3fr_pkg::LEN_W-1:0]       rsp_data_length,
   output logic [esp3fr_pkg::BYTE_W-1:0]      rsp_optional_length,
   output logic [esp3fr_pkg::BYTE_W-1:0]      rsp_pkt_type,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [esp3fr_pkg::CNT_W-1:0]       csr_payload_limit
);

   logic                               in_valid_ff;
   logic [esp3fr_pkg::BYTE_W-1:0]      in_byte_ff;
   logic                               out_valid_ff;
   esp3fr_pkg::result_type             out_ff;
   esp3fr_pkg::result_type             result;
   logic [esp3fr_pkg::CNT_W-1:0]       limit_ff;
   logic                               advance;

   // the held request moves on when the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= esp3fr_pkg::PAYLOAD_LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_payload_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   esp3fr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .rx_byte       (in_byte_ff),
      .payload_limit (limit_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_status              = out_ff.status;
   assign rsp_error_kind          = out_ff.error_kind;
   assign rsp_payload_valid       = out_ff.payload_valid;
   assign rsp_payload_is_optional = out_ff.payload_is_optional;
   assign rsp_payload_byte        = out_ff.payload_byte;
   assign rsp_payload_index       = out_ff.payload_index;
   assign rsp_data_length         = out_ff.data_length;
   assign rsp_optional_length     = out_ff.optional_length;
   assign rsp_pkt_type            = out_ff.pkt_type;

`ifndef SYNTHESIS
   a_kind_only_on_error: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status != esp3fr_pkg::ST_ERROR
         |-> out_ff.error_kind == esp3fr_pkg::ERR_NONE)
      else $error("error kind set without error status");

   a_payload_not_final: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.payload_valid |-> out_ff.status == esp3fr_pkg::ST_BUSY)
      else $error("payload request carries a final status");

   a_held_request_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held request lost while result register busy");
`endif

endmodule
